@@ hw/rtl/art_pkg.sv @@
// Shared types and constants for the activity rest lock timer.
// Used by art_step and by activity_rest_lock_timer_core; depends on nothing.
`default_nettype none

package art_pkg;

  // Mode codes as seen on the result channel.
  localparam logic [1:0] MODE_INIT   = 2'd0;
  localparam logic [1:0] MODE_ACTIVE = 2'd1;
  localparam logic [1:0] MODE_IDLE   = 2'd2;
  localparam logic [1:0] MODE_LOCKED = 2'd3;

  // Input opcodes.
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_PAUSE   = 2'd2;
  localparam logic [1:0] OP_UNPAUSE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WORK_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_IDLE_LIMIT    = 2'd1;
  localparam logic [1:0] CFG_REST_LIMIT    = 2'd2;

  localparam logic [31:0] WORK_INTERVAL_RST = 32'd3600;
  localparam logic [31:0] IDLE_LIMIT_RST    = 32'd300;
  localparam logic [31:0] REST_LIMIT_RST    = 32'd300;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] work_left;
    logic [31:0] idle_count;
    logic [31:0] rest_count;
    logic        paused;
  } timer_state_t;

  typedef struct packed {
    logic [31:0] work_interval;
    logic [31:0] idle_limit;
    logic [31:0] rest_limit;
  } timer_cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] elapsed;
    logic        activity_seen;
  } timer_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic        lock_screen;
    logic [31:0] work_remaining;
    logic        mode_changed;
  } timer_result_t;

  // Adds a 16-bit elapsed time to a 32-bit counter, holding at all ones.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {17'd0, b};
    sat_add = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/activity_rest_lock_timer_core.sv @@
// Top level of the activity rest lock timer: handshakes, registers and state.
// Depends on art_pkg and art_step.
`default_nettype none

// The block is a four-mode rest timer (init, active, idle, locked) driven by
// beats on the input channel: start, tick, pause and unpause. Every input beat
// produces exactly one result beat that reports the mode after the beat, the
// lock output, the remaining work budget and whether the mode changed. An
// accepted beat is captured in an input register; once the result register is
// free or being taken, the step logic (one saturating add or subtract and a
// 32-bit compare per counter) updates the timer state and loads the result
// register. While the result side does not stall, a new beat can be accepted
// every cycle, so the sustained rate is one beat per cycle. The input register
// drains only when the result register is empty or being taken, so a stall on
// the result side reaches in_stall once the input register holds a beat. The
// three configuration registers (work_interval, idle_limit, rest_limit) are
// written through the cfg_ port only while the block is idle, a rule for the
// user that the block itself does not enforce; a write to an index beyond the
// three is ignored. Reset returns the block to init mode with a zero budget
// and counters, unpaused, and with the default register values.

module activity_rest_lock_timer_core (
  input  wire        clk,
  input  wire        rst_n,

  input  wire        cfg_we,
  input  wire [1:0]  cfg_index,
  input  wire [31:0] cfg_wdata,

  input  wire        in_valid,
  output logic       in_stall,
  input  wire [1:0]  in_opcode,
  input  wire [15:0] in_elapsed,
  input  wire        in_activity_seen,

  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_mode,
  output logic       out_lock_screen,
  output logic [31:0] out_work_remaining,
  output logic       out_mode_changed
);

  art_pkg::timer_cfg_t    cfg_r;
  art_pkg::timer_state_t  state_r;
  art_pkg::timer_state_t  state_nxt;
  art_pkg::timer_item_t   item_r;
  art_pkg::timer_result_t res_nxt;
  art_pkg::timer_result_t res_r;
  logic                   item_valid_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   in_take;

  // The held beat moves on whenever the result register is free or is being
  // taken this cycle.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = item_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.work_interval <= art_pkg::WORK_INTERVAL_RST;
      cfg_r.idle_limit    <= art_pkg::IDLE_LIMIT_RST;
      cfg_r.rest_limit    <= art_pkg::REST_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        art_pkg::CFG_WORK_INTERVAL: cfg_r.work_interval <= cfg_wdata;
        art_pkg::CFG_IDLE_LIMIT:    cfg_r.idle_limit    <= cfg_wdata;
        art_pkg::CFG_REST_LIMIT:    cfg_r.rest_limit    <= cfg_wdata;
        default: begin
          // Writes outside the register list are dropped.
        end
      endcase
    end
  end

  // Input register: valid flag with reset, payload without.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode        <= in_opcode;
      item_r.elapsed       <= in_elapsed;
      item_r.activity_seen <= in_activity_seen;
    end
  end

  art_step u_step (
    .cur  (state_r),
    .cfg  (cfg_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Timer state advances once per beat that moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode       <= art_pkg::MODE_INIT;
      state_r.work_left  <= 32'd0;
      state_r.idle_count <= 32'd0;
      state_r.rest_count <= 32'd0;
      state_r.paused     <= 1'b0;
    end else if (item_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = res_r.mode;
  assign out_lock_screen    = res_r.lock_screen;
  assign out_work_remaining = res_r.work_remaining;
  assign out_mode_changed   = res_r.mode_changed;

endmodule

`default_nettype wire

@@ hw/rtl/art_step.sv @@
// Next-state and result logic for one beat of the rest timer.
// Purely combinational; depends on art_pkg.
`default_nettype none

module art_step (
  input  wire art_pkg::timer_state_t  cur,
  input  wire art_pkg::timer_cfg_t    cfg,
  input  wire art_pkg::timer_item_t   item,
  output art_pkg::timer_state_t       nxt,
  output art_pkg::timer_result_t      res
);

  logic [31:0] work_dec;
  logic [31:0] idle_sum;
  logic [31:0] rest_sum;

  always_comb begin
    work_dec = (cur.work_left > {16'd0, item.elapsed}) ?
               (cur.work_left - {16'd0, item.elapsed}) : 32'd0;
    idle_sum = art_pkg::sat_add(cur.idle_count, item.elapsed);
    rest_sum = art_pkg::sat_add(cur.rest_count, item.elapsed);
  end

  always_comb begin
    nxt = cur;
    unique case (item.opcode)
      art_pkg::OP_START: begin
        nxt.mode       = art_pkg::MODE_ACTIVE;
        nxt.work_left  = cfg.work_interval;
        nxt.idle_count = 32'd0;
      end
      art_pkg::OP_TICK: begin
        unique case (cur.mode)
          art_pkg::MODE_ACTIVE: begin
            if (cur.work_left == 32'd0) begin
              // Budget used up: lock and skip the rest of the tick.
              nxt.mode       = art_pkg::MODE_LOCKED;
              nxt.rest_count = 32'd0;
            end else begin
              if (!cur.paused) begin
                nxt.work_left = work_dec;
              end
              nxt.idle_count = item.activity_seen ? 32'd0 : idle_sum;
              if (nxt.idle_count >= cfg.idle_limit) begin
                nxt.mode = art_pkg::MODE_IDLE;
              end
            end
          end
          art_pkg::MODE_IDLE: begin
            if (item.activity_seen) begin
              nxt.mode       = art_pkg::MODE_ACTIVE;
              nxt.work_left  = cfg.work_interval;
              nxt.idle_count = 32'd0;
            end
          end
          art_pkg::MODE_LOCKED: begin
            nxt.rest_count = rest_sum;
            if (rest_sum >= cfg.rest_limit) begin
              nxt.mode       = art_pkg::MODE_ACTIVE;
              nxt.work_left  = cfg.work_interval;
              nxt.idle_count = 32'd0;
            end
          end
          default: begin
            // Ticks before the first start change nothing.
          end
        endcase
      end
      art_pkg::OP_PAUSE: begin
        nxt.paused = 1'b1;
      end
      art_pkg::OP_UNPAUSE: begin
        nxt.paused = 1'b0;
      end
      default: begin
        nxt.paused = cur.paused;
      end
    endcase
  end

  always_comb begin
    res.mode           = nxt.mode;
    res.lock_screen    = (nxt.mode == art_pkg::MODE_LOCKED);
    res.work_remaining = nxt.work_left;
    res.mode_changed   = (nxt.mode != cur.mode);
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_activity_rest_lock_timer_core.sv @@
// Self-checking testbench for activity_rest_lock_timer_core: directed, long-count and
// random beats, with a behavioral timer model predicting every result beat.
// Depends on art_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_activity_rest_lock_timer_core;

  // A failing run is cut off here. The slowest correct run (about 1300 beats, each
  // behind a sender gap and the heaviest receiver stall) needs far fewer cycles
  // than this limit.
  localparam int unsigned CYCLE_LIMIT = 250_000;

  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic [1:0]  in_opcode = art_pkg::OP_START;
  logic [15:0] in_elapsed = '0;
  logic        in_activity_seen = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_mode;
  logic        out_lock_screen;
  logic [31:0] out_work_remaining;
  logic        out_mode_changed;

  activity_rest_lock_timer_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_elapsed         (in_elapsed),
    .in_activity_seen   (in_activity_seen),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mode           (out_mode),
    .out_lock_screen    (out_lock_screen),
    .out_work_remaining (out_work_remaining),
    .out_mode_changed   (out_mode_changed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Timer model: the testbench's own copy of the mode, counters and registers.
  logic [1:0]  tmr_mode;
  logic [31:0] tmr_budget;
  logic [31:0] tmr_idle_time;
  logic [31:0] tmr_rest_time;
  logic        tmr_paused;
  logic [31:0] set_work_interval;
  logic [31:0] set_idle_limit;
  logic [31:0] set_rest_limit;

  // Results the model has predicted and the block has not yet delivered, oldest first.
  art_pkg::timer_result_t expected_results[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Sender pacing: beats go out in bursts separated by idle gaps, unless the
  // current test asks for a steady stream.
  bit          sender_steady = 1'b0;
  int unsigned burst_left = 0;

  // Receiver pacing: a stall style is held for a random stretch, then replaced.
  stall_style_t stall_style = STALL_NONE;
  int unsigned  style_left = 0;
  int unsigned  stall_period = 2;

  function automatic logic [31:0] add_saturating(input logic [31:0] acc,
                                                 input logic [15:0] dt);
    if (acc > 32'hFFFF_FFFF - {16'd0, dt})
      return 32'hFFFF_FFFF;
    return acc + {16'd0, dt};
  endfunction

  // Entering active reloads the budget and forgets any inactivity.
  task automatic resume_work();
    tmr_mode = art_pkg::MODE_ACTIVE;
    tmr_budget = set_work_interval;
    tmr_idle_time = '0;
  endtask

  task automatic advance_timer(input logic [1:0] op, input logic [15:0] dt, input logic act,
                               output art_pkg::timer_result_t res);
    logic [1:0] mode_before;
    mode_before = tmr_mode;
    case (op)
      art_pkg::OP_START: resume_work();
      art_pkg::OP_TICK: begin
        case (tmr_mode)
          art_pkg::MODE_ACTIVE: begin
            // An exhausted budget locks, and the tick does nothing else.
            if (tmr_budget == '0) begin
              tmr_mode = art_pkg::MODE_LOCKED;
              tmr_rest_time = '0;
            end else begin
              if (!tmr_paused)
                tmr_budget = (tmr_budget > {16'd0, dt}) ? tmr_budget - {16'd0, dt} : '0;
              tmr_idle_time = act ? '0 : add_saturating(tmr_idle_time, dt);
              if (tmr_idle_time >= set_idle_limit)
                tmr_mode = art_pkg::MODE_IDLE;
            end
          end
          art_pkg::MODE_IDLE: if (act) resume_work();
          art_pkg::MODE_LOCKED: begin
            tmr_rest_time = add_saturating(tmr_rest_time, dt);
            if (tmr_rest_time >= set_rest_limit)
              resume_work();
          end
          default: ;
        endcase
      end
      art_pkg::OP_PAUSE: tmr_paused = 1'b1;
      default: tmr_paused = 1'b0;
    endcase
    res.mode = tmr_mode;
    res.lock_screen = (tmr_mode == art_pkg::MODE_LOCKED);
    res.work_remaining = tmr_budget;
    res.mode_changed = (tmr_mode != mode_before);
  endtask

  // Holds the input channel empty, with noise on the payload.
  task automatic hold_input(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_opcode = 2'($urandom);
      in_elapsed = 16'($urandom);
      in_activity_seen = 1'($urandom);
    end
  endtask

  // Sends one beat, waits until the block takes it, and records its prediction.
  task automatic send_command(input logic [1:0] op, input logic [15:0] dt, input logic act);
    art_pkg::timer_result_t want;
    if (!sender_steady && burst_left == 0) begin
      hold_input($urandom_range(1, 12));
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0)
      burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_opcode = op;
    in_elapsed = dt;
    in_activity_seen = act;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_timer(op, dt, act, want);
    expected_results.push_back(want);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Only called while the block is idle, so the model can follow at once.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      art_pkg::CFG_WORK_INTERVAL: set_work_interval = data;
      art_pkg::CFG_IDLE_LIMIT: set_idle_limit = data;
      art_pkg::CFG_REST_LIMIT: set_rest_limit = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure_timer(input logic [31:0] work, input logic [31:0] idle_lim,
                                 input logic [31:0] rest_lim);
    wait_for_results();
    write_register(art_pkg::CFG_WORK_INTERVAL, work);
    write_register(art_pkg::CFG_IDLE_LIMIT, idle_lim);
    write_register(art_pkg::CFG_REST_LIMIT, rest_lim);
  endtask

  // Walks every mode transition and opcode with the reset register values
  // (budget 3600, idle limit 300, rest limit 300).
  task automatic test_directed_sequence();
    send_command(art_pkg::OP_TICK, 16'hFFFF, 1'b1);     // tick in init changes nothing
    send_command(art_pkg::OP_PAUSE, 16'h0000, 1'b0);
    send_command(art_pkg::OP_UNPAUSE, 16'hFFFF, 1'b1);
    send_command(art_pkg::OP_START, 16'h0000, 1'b0);    // init to active, budget loaded
    send_command(art_pkg::OP_TICK, 16'h0000, 1'b1);
    send_command(art_pkg::OP_TICK, 16'd100, 1'b0);
    send_command(art_pkg::OP_START, 16'h0000, 1'b0);    // reload from active
    send_command(art_pkg::OP_PAUSE, 16'h0000, 1'b0);
    send_command(art_pkg::OP_TICK, 16'd200, 1'b0);      // paused: budget holds
    send_command(art_pkg::OP_UNPAUSE, 16'h0000, 1'b0);
    send_command(art_pkg::OP_TICK, 16'd100, 1'b0);      // idle time reaches the limit
    send_command(art_pkg::OP_TICK, 16'hFFFF, 1'b0);     // idle without activity stays
    send_command(art_pkg::OP_TICK, 16'd5, 1'b1);        // activity returns to active
    send_command(art_pkg::OP_TICK, 16'hFFFF, 1'b1);     // budget runs out, holds at zero
    send_command(art_pkg::OP_TICK, 16'h0000, 1'b1);     // empty budget locks
    send_command(art_pkg::OP_TICK, 16'd299, 1'b1);
    send_command(art_pkg::OP_TICK, 16'd1, 1'b0);        // rest time reaches the limit
    send_command(art_pkg::OP_TICK, 16'hFFFF, 1'b1);
    send_command(art_pkg::OP_TICK, 16'h0000, 1'b0);
    send_command(art_pkg::OP_START, 16'h0000, 1'b0);    // start from locked
    send_command(art_pkg::OP_TICK, 16'd300, 1'b0);
    send_command(art_pkg::OP_START, 16'h0000, 1'b1);    // start from idle
    send_command(art_pkg::OP_PAUSE, 16'h0000, 1'b0);
    send_command(art_pkg::OP_START, 16'h0000, 1'b0);    // pause survives a start
    send_command(art_pkg::OP_TICK, 16'd50, 1'b1);
    send_command(art_pkg::OP_UNPAUSE, 16'h0000, 1'b0);
  endtask

  // Zero limits: locking and unlocking on the first tick, idle even with activity.
  task automatic test_zero_limits();
    configure_timer('0, '0, '0);
    write_register(CFG_SPARE_INDEX, '1);
    send_command(art_pkg::OP_START, 16'h0000, 1'b0);
    send_command(art_pkg::OP_TICK, 16'd7, 1'b1);
    send_command(art_pkg::OP_TICK, 16'h0000, 1'b0);
    send_command(art_pkg::OP_TICK, 16'h0000, 1'b1);
    wait_for_results();
    write_register(art_pkg::CFG_WORK_INTERVAL, 32'd10);
    send_command(art_pkg::OP_START, 16'h0000, 1'b0);
    send_command(art_pkg::OP_TICK, 16'd3, 1'b1);
    send_command(art_pkg::OP_TICK, 16'd3, 1'b1);
    send_command(art_pkg::OP_TICK, 16'hFFFF, 1'b1);
  endtask

  // Runs the inactivity and rest counters up by the largest step under all-ones
  // limits: neither counter reaches its limit, a paused all-ones budget holds,
  // and an empty budget locks on the first tick.
  task automatic test_long_counts();
    sender_steady = 1'b1;
    configure_timer('1, '1, '1);
    send_command(art_pkg::OP_START, 16'h0000, 1'b0);
    send_command(art_pkg::OP_PAUSE, 16'h0000, 1'b0);
    send_command(art_pkg::OP_TICK, 16'd1, 1'b0);
    repeat (16)
      send_command(art_pkg::OP_TICK, 16'hFFFF, 1'b0);
    send_command(art_pkg::OP_UNPAUSE, 16'h0000, 1'b0);
    wait_for_results();
    write_register(art_pkg::CFG_WORK_INTERVAL, '0);
    send_command(art_pkg::OP_START, 16'h0000, 1'b0);
    send_command(art_pkg::OP_TICK, 16'h0000, 1'b0);
    send_command(art_pkg::OP_TICK, 16'd1, 1'b1);
    repeat (16)
      send_command(art_pkg::OP_TICK, 16'hFFFF, 1'($urandom));
    sender_steady = 1'b0;
  endtask

  // One random beat: mostly ticks, elapsed times mostly within dt_span.
  task automatic send_random_command(input int unsigned dt_span, input int unsigned act_pct);
    int unsigned pick;
    logic [1:0]  op;
    logic [15:0] dt;
    pick = $urandom_range(0, 99);
    if (pick < 8)
      op = art_pkg::OP_START;
    else if (pick < 14)
      op = art_pkg::OP_PAUSE;
    else if (pick < 22)
      op = art_pkg::OP_UNPAUSE;
    else
      op = art_pkg::OP_TICK;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      dt = 16'h0000;
    else if (pick < 10)
      dt = 16'hFFFF;
    else if (pick < 30)
      dt = 16'($urandom);
    else
      dt = 16'($urandom_range(0, dt_span));
    send_command(op, dt, $urandom_range(0, 99) < act_pct);
  endtask

  // Phases of random beats, each under its own register setting. Every phase
  // opens with a start so that the beats reach the active, idle and locked modes.
  task automatic test_random_phases();
    int unsigned dt_span;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin configure_timer(32'd3600, 32'd300, 32'd300); dt_span = 400; end
        1: begin configure_timer(32'd500, 32'd120, 32'd80); dt_span = 60; end
        2: begin configure_timer('0, '0, '0); dt_span = 20; end
        3: begin configure_timer('1, '1, '1); dt_span = 65535; end
        4: begin
          configure_timer($urandom_range(0, 2000), $urandom_range(0, 400),
                          $urandom_range(0, 400));
          dt_span = 100;
        end
        5: begin configure_timer($urandom, $urandom, $urandom); dt_span = 65535; end
        6: begin configure_timer(32'd1, '1, '0); dt_span = 10; end
        default: begin
          configure_timer($urandom_range(0, 800), $urandom_range(0, 200),
                          $urandom_range(0, 200));
          dt_span = 200;
        end
      endcase
      // Odd phases run the sender without gaps.
      sender_steady = phase[0];
      send_command(art_pkg::OP_START, 16'($urandom), 1'($urandom));
      repeat (150)
        send_random_command(dt_span, $urandom_range(20, 70));
    end
    sender_steady = 1'b0;
  endtask

  // Receiver: out_stall follows a style that is held for a random stretch, then replaced.
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(20, 200);
      stall_period = $urandom_range(2, 4);
    end
    style_left--;
    case (stall_style)
      STALL_NONE: out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 99) < 25);
      STALL_HEAVY: out_stall = ($urandom_range(0, 99) < 60);
      default: out_stall = (cycle_count % stall_period) != 0;
    endcase
  end

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Every result beat taken is checked against the oldest prediction.
  always @(posedge clk) begin : check_results
    art_pkg::timer_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, mode %0d work_remaining 0x%0h",
                 $time, out_mode, out_work_remaining);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("mode", 32'(want.mode), 32'(out_mode));
        compare_field("lock_screen", 32'(want.lock_screen), 32'(out_lock_screen));
        compare_field("work_remaining", want.work_remaining, out_work_remaining);
        compare_field("mode_changed", 32'(want.mode_changed), 32'(out_mode_changed));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, expected_results.size());
      $display("tb_activity_rest_lock_timer_core: errors");
      $finish;
    end
  end

  initial begin
    tmr_mode = art_pkg::MODE_INIT;
    tmr_budget = '0;
    tmr_idle_time = '0;
    tmr_rest_time = '0;
    tmr_paused = 1'b0;
    set_work_interval = art_pkg::WORK_INTERVAL_RST;
    set_idle_limit = art_pkg::IDLE_LIMIT_RST;
    set_rest_limit = art_pkg::REST_LIMIT_RST;

    // Synchronous reset, held low from time zero and released at a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_sequence();
    test_zero_limits();
    test_long_counts();
    test_random_phases();

    // Drain, then give the two-register pipeline time to show any stray beat.
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("tb_activity_rest_lock_timer_core: clean");
    else
      $display("tb_activity_rest_lock_timer_core: errors");
    $finish;
  end

endmodule

@@ activity_rest_lock_timer_core.f @@
hw/rtl/art_pkg.sv
hw/rtl/art_step.sv
hw/rtl/activity_rest_lock_timer_core.sv
tb/sv/tb_activity_rest_lock_timer_core.sv
